/* sv/tds_pkg.sv */
// Shared constants, types and the log2 fraction table generator for the TF-IDF scorer.
`default_nettype none

package tds_pkg;

   localparam int DATA_W             = 32;
   localparam int LOG_INT_W          = 5;
   localparam int SCORE_W            = 64;
   localparam int LOG_TABLE_BITS_DEF = 8;
   localparam int FRAC_BITS_DEF      = 16;
   localparam int QUEUE_DEPTH        = 16;

   // ln(2) in Q0.32
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   localparam logic [SCORE_W-1:0] SUM_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic [SCORE_W-1:0] SUM_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   // flags that ride with each term through the queue
   typedef struct packed {
      logic last;
      logic zdocs;
      logic neg;
   } term_flags_type;

   localparam int FLAGS_W = $bits(term_flags_type);

   // per-term side data carried down the front pipeline
   typedef struct packed {
      logic [DATA_W-1:0] tag;
      logic [DATA_W-1:0] tf;
      logic              last;
      logic              skip;
      logic              zdocs;
   } term_meta_type;

   // fraction of log2(1 + idx / 2^tbits), fbits bits, by repeated squaring in Q2.30
   function automatic logic [31:0] tds_log_entry(input int idx, input int tbits,
                                                 input int fbits);
      logic [63:0] y;
      logic [31:0] r;
      y = (64'(1) << tbits) + 64'(idx);
      y = y << (30 - tbits);
      r = '0;
      for (int b = 0; b < fbits; b++) begin
         y = (y * y) >> 30;
         if (y >= 64'h0000_0000_8000_0000) begin
            r = {r[30:0], 1'b1};
            y = y >> 1;
         end else begin
            r = {r[30:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/tds_log2.sv */
// Two-stage fixed-point log2: leading-one position, then fraction table lookup.
`default_nettype none

module tds_log2 import tds_pkg::*; #(
   parameter int TBITS = LOG_TABLE_BITS_DEF,
   parameter int FBITS = FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic [DATA_W-1:0]          x,
   output logic      [LOG_INT_W+FBITS-1:0] log_out
);

   logic [LOG_INT_W-1:0]       pos_in,  pos_ff;
   logic [TBITS-1:0]           idx_in,  idx_ff;
   logic [DATA_W-1:0]          xn;
   logic [LOG_INT_W+FBITS-1:0] log_in,  log_ff;
   logic [FBITS-1:0]           frac_tbl [2**TBITS];

   for (genvar i = 0; i < 2**TBITS; i++) begin : g_tbl
      localparam logic [FBITS-1:0] ENT = FBITS'(tds_log_entry(i, TBITS, FBITS));
      assign frac_tbl[i] = ENT;
   end

   // priority encode, then normalize so the leading one sits at the top bit
   always_comb begin
      pos_in = '0;
      for (int k = 0; k < DATA_W; k++) begin
         if (x[k]) begin
            pos_in = LOG_INT_W'(k);
         end
      end
      xn     = x << (LOG_INT_W'(DATA_W - 1) - pos_in);
      idx_in = xn[DATA_W-2 -: TBITS];
   end

   assign log_in = {pos_ff, frac_tbl[idx_ff]};

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      log_ff <= log_in;
   end

   assign log_out = log_ff;

endmodule

`default_nettype wire

/* sv/tds_front.sv */
// Front end: accepts terms, holds total_docs, computes each term's |tf * idf|.
`default_nettype none

module tds_front import tds_pkg::*; #(
   parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [DATA_W-1:0]                     csr_wdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [3*DATA_W-1:0]                   req_tdata,
   input  wire logic                                  req_tlast,
   input  wire logic                                  q_pop,
   output logic                                       q_push,
   output logic [DATA_W-1:0]                          q_tag,
   output logic [DATA_W+LOG_INT_W+FRAC_BITS-1:0]      q_mag,
   output term_flags_type                             q_flags
);

   localparam int LW     = LOG_INT_W + FRAC_BITS;
   localparam int PROD_W = LW + 32;
   localparam int MAG_W  = DATA_W + LW;
   localparam int NSTG   = 6;
   localparam int CW     = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0]  total_docs_in, total_docs_ff;
   logic [CW-1:0]      credit_in, credit_ff;
   logic               accept;
   logic [DATA_W-1:0]  in_tag, in_tf, in_df;
   logic [DATA_W-1:0]  df_ff;
   term_meta_type      meta_in;
   term_meta_type      meta_ff  [NSTG];
   logic [NSTG-1:0]    valid_ff;
   logic [LW-1:0]      log_n, log_d;
   logic               neg_d_in, neg_d_ff, neg_e_ff, neg_f_ff;
   logic [LW-1:0]      dmag_in, dmag_ff;
   logic [PROD_W-1:0]  prod_in, prod_ff, rnd;
   logic [LW-1:0]      imag_in, imag_ff;
   logic [MAG_W-1:0]   mag_in, mag_ff;
   logic               push_ff;
   logic [DATA_W-1:0]  tag_ff;
   term_flags_type     flags_in, flags_ff;

   assign total_docs_in = csr_we ? csr_wdata : total_docs_ff;

   // credit covers words in flight plus words queued, so a push always fits
   assign req_tready = credit_ff < CW'(QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;
   assign credit_in  = credit_ff + CW'(accept) - CW'(q_pop);

   assign in_tag = req_tdata[DATA_W-1:0];
   assign in_tf  = req_tdata[2*DATA_W-1:DATA_W];
   assign in_df  = req_tdata[3*DATA_W-1:2*DATA_W];

   always_comb begin
      meta_in.tag   = in_tag;
      meta_in.tf    = in_tf;
      meta_in.last  = req_tlast;
      meta_in.zdocs = total_docs_ff == '0;
      meta_in.skip  = (in_tf == '0) || (in_df == '0) || (total_docs_ff == '0);
   end

   tds_log2 #(.TBITS(LOG_TABLE_BITS), .FBITS(FRAC_BITS)) u_log_n (
      .clock   (clock),
      .x       (total_docs_ff),
      .log_out (log_n)
   );

   tds_log2 #(.TBITS(LOG_TABLE_BITS), .FBITS(FRAC_BITS)) u_log_d (
      .clock   (clock),
      .x       (df_ff),
      .log_out (log_d)
   );

   // log outputs line up with stage 2
   always_comb begin
      neg_d_in = log_d > log_n;
      dmag_in  = neg_d_in ? (log_d - log_n) : (log_n - log_d);
      prod_in  = PROD_W'(dmag_ff) * PROD_W'(LN2_Q32);
      rnd      = prod_ff + (PROD_W'(1) << 31);
      imag_in  = rnd[PROD_W-1:32];
      mag_in   = meta_ff[NSTG-1].skip ? '0 : MAG_W'(meta_ff[NSTG-1].tf) * MAG_W'(imag_ff);
      flags_in.last  = meta_ff[NSTG-1].last;
      flags_in.zdocs = meta_ff[NSTG-1].zdocs;
      flags_in.neg   = neg_f_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_docs_ff <= '0;
         credit_ff     <= '0;
         valid_ff      <= '0;
         push_ff       <= 1'b0;
      end else begin
         total_docs_ff <= total_docs_in;
         credit_ff     <= credit_in;
         valid_ff      <= {valid_ff[NSTG-2:0], accept};
         push_ff       <= valid_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      df_ff      <= in_df;
      meta_ff[0] <= meta_in;
      for (int s = 1; s < NSTG; s++) begin
         meta_ff[s] <= meta_ff[s-1];
      end
      neg_d_ff <= neg_d_in;
      dmag_ff  <= dmag_in;
      neg_e_ff <= neg_d_ff;
      prod_ff  <= prod_in;
      neg_f_ff <= neg_e_ff;
      imag_ff  <= imag_in;
      mag_ff   <= mag_in;
      tag_ff   <= meta_ff[NSTG-1].tag;
      flags_ff <= flags_in;
   end

   assign q_push  = push_ff;
   assign q_tag   = tag_ff;
   assign q_mag   = mag_ff;
   assign q_flags = flags_ff;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CW'(QUEUE_DEPTH))
      else $error("front credit above queue depth");

   a_pop_has_credit: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> credit_ff != '0)
      else $error("queue pop without outstanding credit");

endmodule

`default_nettype wire

/* sv/tds_queue.sv */
// Small FIFO between front and back ends.
`default_nettype none

module tds_queue import tds_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic                  rvalid,
   output logic      [WIDTH-1:0] rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_in, wr_ptr_ff, rd_ptr_in, rd_ptr_ff;
   logic [NW-1:0]    count_in, count_ff;

   assign wr_ptr_in = push ? AW'(wr_ptr_ff + AW'(1)) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? AW'(rd_ptr_ff + AW'(1)) : rd_ptr_ff;
   assign count_in  = count_ff + NW'(push) - NW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   assign rvalid = count_ff != '0;
   assign rdata  = mem[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < NW'(DEPTH)) || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> rvalid)
      else $error("queue pop while empty");

endmodule

`default_nettype wire

/* sv/tds_back.sv */
// Back end: saturating accumulation of term scores and the result register.
`default_nettype none

module tds_back import tds_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  q_valid,
   input  wire logic [DATA_W-1:0]                     q_tag,
   input  wire logic [DATA_W+LOG_INT_W+FRAC_BITS-1:0] q_mag,
   input  wire term_flags_type                        q_flags,
   output logic                                       q_pop,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [DATA_W+SCORE_W-1:0]                  rsp_tdata,
   output logic                                       rsp_tuser
);

   logic [SCORE_W-1:0] sum_in, sum_ff, addend, sum_add, sum_new;
   logic               clip_in, clip_ff, clip_new, ovf;
   logic               out_free, fin;
   logic               rsp_valid_in, rsp_valid_ff;
   logic [DATA_W-1:0]  tag_ff;
   logic [SCORE_W-1:0] score_ff;
   logic               sat_ff;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      q_pop    = q_valid && (!q_flags.last || out_free);
      fin      = q_pop && q_flags.last;
      addend   = q_flags.neg ? (SCORE_W'(0) - SCORE_W'(q_mag)) : SCORE_W'(q_mag);
      sum_add  = sum_ff + addend;
      ovf      = (sum_ff[SCORE_W-1] == addend[SCORE_W-1]) &&
                 (sum_add[SCORE_W-1] != sum_ff[SCORE_W-1]);
      sum_new  = ovf ? (sum_ff[SCORE_W-1] ? SUM_MIN : SUM_MAX) : sum_add;
      clip_new = clip_ff || ovf;

      sum_in  = sum_ff;
      clip_in = clip_ff;
      if (q_pop) begin
         sum_in  = q_flags.last ? '0   : sum_new;
         clip_in = q_flags.last ? 1'b0 : clip_new;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (fin) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         tag_ff   <= q_tag;
         score_ff <= q_flags.zdocs ? '0   : sum_new;
         sat_ff   <= q_flags.zdocs ? 1'b0 : clip_new;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {score_ff, tag_ff};
   assign rsp_tuser  = sat_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      fin |=> (sum_ff == '0) && !clip_ff)
      else $error("running sum not cleared after last term");

   a_zero_docs_result: assert property (@(posedge clock) disable iff (reset)
      fin && q_flags.zdocs |=> rsp_tvalid && (score_ff == '0) && !rsp_tuser)
      else $error("nonzero result with empty collection");

endmodule

`default_nettype wire

/* sv/tfidf_document_score.sv */
// TF-IDF document scorer: top level joining front end, term queue and accumulator.
//
// Usage:
//  - Configure total_docs through csr_we / csr_wdata while the block is idle;
//    reset leaves it at zero, which makes every score zero.
//  - Each req word is one query term: tf and df of the term for one document,
//    with req_tlast on the document's final term. Terms of a document are
//    contiguous; one rsp word comes back per document, on its last term.
//  - rsp_tdata carries the document tag and a signed score with FRAC_BITS
//    fraction bits; rsp_tuser flags that the sum saturated along the way.
// Timing:
//  - One word per cycle sustained while req_tready is high. A last term's result passes
//    through 7 pipeline stages in the front end (input register, log2 encode,
//    table lookup, idf difference, ln2 multiply, rounding, tf multiply), one
//    queue write, then the accumulator add into the result register.
//  - The front end issues on credit for the 16-entry queue, so a stalled
//    rsp side fills the queue and then drops req_tready; no word is lost.
//  - Reset (synchronous, active high) empties the pipeline, queue and sum.
`default_nettype none

module tfidf_document_score import tds_pkg::*; #(
   parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // configuration: total_docs
   input  wire logic                         csr_we,
   input  wire logic [DATA_W-1:0]            csr_wdata,
   // term words
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [3*DATA_W-1:0]          req_tdata,  // doc_tag, term_freq, doc_freq
   input  wire logic                         req_tlast,  // last_term
   // result words
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [DATA_W+SCORE_W-1:0]         rsp_tdata,  // doc_id_out, doc_score
   output logic                              rsp_tuser   // saturated
);

   localparam int MAG_W   = DATA_W + LOG_INT_W + FRAC_BITS;
   localparam int ENTRY_W = DATA_W + MAG_W + FLAGS_W;

   logic               push, pop, q_valid;
   logic [DATA_W-1:0]  push_tag, head_tag;
   logic [MAG_W-1:0]   push_mag, head_mag;
   term_flags_type     push_flags, head_flags;
   logic [ENTRY_W-1:0] head_data;

   tds_front #(.LOG_TABLE_BITS(LOG_TABLE_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_pop      (pop),
      .q_push     (push),
      .q_tag      (push_tag),
      .q_mag      (push_mag),
      .q_flags    (push_flags)
   );

   tds_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  ({push_tag, push_mag, push_flags}),
      .pop    (pop),
      .rvalid (q_valid),
      .rdata  (head_data)
   );

   assign head_flags = term_flags_type'(head_data[FLAGS_W-1:0]);
   assign head_mag   = head_data[FLAGS_W+MAG_W-1:FLAGS_W];
   assign head_tag   = head_data[ENTRY_W-1:FLAGS_W+MAG_W];

   tds_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_tag      (head_tag),
      .q_mag      (head_mag),
      .q_flags    (head_flags),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
